// ----- hw/rtl/firl_pkg.sv -----
// ---------------------------------------------------------------------------
// firl_pkg
// Shared types and constants of the long direct-form FIR filter.
// ---------------------------------------------------------------------------
package firl_pkg;

    localparam int MAX_TAPS_DEFAULT = 1024;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int TAPS_W   = 11;
    localparam int IDX_W    = 10;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 11'd1001;

    // operation codes carried in tuser
    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    // tag travelling with each memory read down the mac pipeline
    typedef struct packed {
        logic valid;
        logic zero;
        logic first;
        logic last;
    } mac_tag_t;

endpackage

// ----- hw/rtl/firl_ram.sv -----
// ---------------------------------------------------------------------------
// firl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module firl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/firl_mac.sv -----
// ---------------------------------------------------------------------------
// firl_mac
// Multiply-accumulate pipeline with round half up and Q1.15 saturation.
// ---------------------------------------------------------------------------
module firl_mac #(
    parameter int MAX_TAPS = firl_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  firl_pkg::mac_tag_t            tag,
    input  logic [firl_pkg::COEF_W-1:0]   coef,
    input  logic [firl_pkg::SAMPLE_W-1:0] hist,
    output logic                          res_done,
    output logic [firl_pkg::SAMPLE_W-1:0] res_filtered,
    output logic                          res_sat
);

    localparam int PROD_W = firl_pkg::COEF_W + firl_pkg::SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int RND_W  = ACC_W + 1;
    localparam logic signed [RND_W-1:0] RND_BIAS = RND_W'(16384);
    localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO   = RND_W'(-32768);

    // product stage
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     p_valid_reg, p_valid_next;
    logic                     p_first_reg, p_first_next;
    logic                     p_last_reg, p_last_next;
    // accumulate stage
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     a_last_reg, a_last_next;
    // result stage
    logic                     done_reg, done_next;
    logic [firl_pkg::SAMPLE_W-1:0] filt_reg, filt_next;
    logic                     sat_reg, sat_next;

    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [RND_W-1:0]  biased;
    logic signed [RND_W-1:0]  shifted;

    always_comb
    begin
        // masked taps contribute nothing
        prod_next = '0;
        if (!tag.zero)
        begin
            prod_next = $signed(coef) * $signed(hist);
        end
        p_valid_next = tag.valid;
        p_first_next = tag.first;
        p_last_next  = tag.valid & tag.last;

        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_next = acc_reg;
        if (p_valid_reg)
        begin
            acc_next = p_first_reg ? prod_ext : acc_reg + prod_ext;
        end
        a_last_next = p_last_reg;

        // floor((acc + 2^14) / 2^15), then clip
        biased  = {acc_reg[ACC_W-1], acc_reg} + RND_BIAS;
        shifted = biased >>> 15;
        done_next = a_last_reg;
        filt_next = filt_reg;
        sat_next  = sat_reg;
        if (a_last_reg)
        begin
            priority if (shifted > SAT_HI)
            begin
                filt_next = 16'h7fff;
                sat_next  = 1'b1;
            end
            else if (shifted < SAT_LO)
            begin
                filt_next = 16'h8000;
                sat_next  = 1'b1;
            end
            else
            begin
                filt_next = shifted[firl_pkg::SAMPLE_W-1:0];
                sat_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            a_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            p_last_reg  <= p_last_next;
            a_last_reg  <= a_last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        p_first_reg <= p_first_next;
        acc_reg     <= acc_next;
        filt_reg    <= filt_next;
        sat_reg     <= sat_next;
    end

    assign res_done     = done_reg;
    assign res_filtered = filt_reg;
    assign res_sat      = sat_reg;

endmodule

// ----- hw/rtl/firl_seq.sv -----
// ---------------------------------------------------------------------------
// firl_seq
// Sequencer: accepts beats, keeps the history pointer and fill count,
// and walks the taps through both memories.
// ---------------------------------------------------------------------------
module firl_seq #(
    parameter int MAX_TAPS = firl_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [firl_pkg::TAPS_W-1:0]      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_op,
    input  logic [firl_pkg::IDX_W-1:0]       in_coef_index,
    input  logic                             in_block_start,
    output logic                             coef_wr_en,
    output logic [$clog2(MAX_TAPS)-1:0]      coef_wr_addr,
    output logic                             hist_wr_en,
    output logic [$clog2(MAX_TAPS)-1:0]      hist_wr_addr,
    output logic                             rd_en,
    output logic [$clog2(MAX_TAPS)-1:0]      coef_rd_addr,
    output logic [$clog2(MAX_TAPS)-1:0]      hist_rd_addr,
    output firl_pkg::mac_tag_t               tag,
    input  logic                             res_done,
    input  logic                             out_free,
    output logic                             out_load
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0]    HEAD_LAST = AW'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0] TAPS_MAX  = CNT_W'(MAX_TAPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [firl_pkg::TAPS_W-1:0] taps_reg, taps_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic [CNT_W-1:0]            lim_reg, lim_next;
    logic [CNT_W-1:0]            k_reg, k_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    firl_pkg::mac_tag_t          tag_reg, tag_next;

    logic          accept;
    logic          filter_go;
    logic          idx_ok;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] new_head;
    logic [CNT_W-1:0] taps_lim;
    logic          last_issue;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid & in_ready;
        filter_go = accept & (in_op == firl_pkg::OP_FILTER);
        idx_ok    = (32'(in_coef_index) < 32'(MAX_TAPS));

        head_inc = (head_reg == HEAD_LAST) ? '0 : head_reg + AW'(1);
        new_head = in_block_start ? '0 : head_inc;

        taps_lim = (32'(taps_reg) > 32'(MAX_TAPS)) ? TAPS_MAX : CNT_W'(taps_reg);

        coef_wr_en   = accept & (in_op == firl_pkg::OP_COEF) & idx_ok;
        coef_wr_addr = AW'(in_coef_index);
        hist_wr_en   = filter_go;
        hist_wr_addr = new_head;

        rd_en        = (state_reg == ST_RUN);
        coef_rd_addr = k_reg[AW-1:0];
        hist_rd_addr = ptr_reg;

        last_issue = (lim_reg == '0) || (k_reg == lim_reg - CNT_W'(1));
        out_load   = (state_reg == ST_OUT) & out_free;

        state_next = state_reg;
        taps_next  = cfg_wr_en ? cfg_wr_data : taps_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        lim_next   = lim_reg;
        k_next     = k_reg;
        ptr_next   = ptr_reg;
        tag_next   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (filter_go)
                begin
                    // block start drops all older samples
                    head_next  = new_head;
                    ptr_next   = new_head;
                    fill_next  = in_block_start ? CNT_W'(1) :
                                 ((fill_reg == TAPS_MAX) ? fill_reg : fill_reg + CNT_W'(1));
                    lim_next   = taps_lim;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                tag_next.valid = 1'b1;
                tag_next.zero  = (lim_reg == '0) || (k_reg >= fill_reg);
                tag_next.first = (k_reg == '0);
                tag_next.last  = last_issue;
                k_next   = k_reg + CNT_W'(1);
                ptr_next = (ptr_reg == '0) ? HEAD_LAST : ptr_reg - AW'(1);
                if (last_issue)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (res_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            taps_reg  <= firl_pkg::TAPS_RESET;
            head_reg  <= '0;
            fill_reg  <= '0;
            lim_reg   <= '0;
            k_reg     <= '0;
            ptr_reg   <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            taps_reg  <= taps_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            lim_reg   <= lim_next;
            k_reg     <= k_next;
            ptr_reg   <= ptr_next;
            tag_reg   <= tag_next;
        end
    end

    assign tag = tag_reg;

`ifndef ASSERT_OFF
    // a result only comes back for the sample being worked on
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |-> (state_reg == ST_WAIT))
        else $error("mac result outside wait state");

    // fill count never passes the history depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= TAPS_MAX)
        else $error("fill count beyond depth");

    // tap counter stays inside the coefficient memory while issuing
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg < TAPS_MAX))
        else $error("tap counter out of range");

    // the last read of a sample is followed by the wait state
    a_last_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_reg.valid && tag_reg.last) |-> (state_reg == ST_WAIT))
        else $error("last tap issued without leaving run state");
`endif

endmodule

// ----- hw/rtl/fir_filter_long.sv -----
// ---------------------------------------------------------------------------
// fir_filter_long
// Direct-form FIR filter over a coefficient memory and a circular history.
// ---------------------------------------------------------------------------
// A coefficient beat (tuser op = 0) writes one Q1.15 coefficient and leaves
// s_tready high; an index at or above MAX_TAPS is dropped and no result beat
// follows. A sample beat (op = 1) is written into the circular history and
// then the filter walks the taps with one shared multiply-accumulate, reading
// one coefficient and one history word per cycle from two single-port-read
// memories, where taps is taps_in_use clipped to MAX_TAPS. After its handshake
// a sample beat holds s_tready low while the taps are read, the read, product,
// accumulate and rounding stages drain and the result is handed to the output
// register, so no new sample is taken before the last result has reached it.
// The hand-off stalls while an earlier result still waits in the output
// register for m_tready. The sum is rounded half up to Q1.15, clipped, and the
// clip is flagged in m_tuser. block_start clears the history before its
// sample; history older than the last start or reset reads as zero through a
// fill count, so reset needs no clearing pass. taps_in_use is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while idle, and the
// block itself does not enforce this. The result sits in an output register,
// so the next beat is taken while a finished result still waits for m_tready.
// ---------------------------------------------------------------------------
module fir_filter_long #(
    parameter int MAX_TAPS = firl_pkg::MAX_TAPS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // coef_index [9:0], coef_value [25:10], sample [41:26], block_start [42]
    input  logic [47:0] s_tdata,
    // op [0]
    input  logic [0:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // filtered [15:0]
    output logic [15:0] m_tdata,
    // saturated [0]
    output logic [0:0]  m_tuser,
    // taps_in_use register
    input  logic                              cfg_wr_en,
    input  logic [firl_pkg::TAPS_W-1:0]       cfg_wr_data
);

    localparam int AW = $clog2(MAX_TAPS);

    // unpacked input beat
    logic                            in_op;
    logic [firl_pkg::IDX_W-1:0]      in_coef_index;
    logic [firl_pkg::COEF_W-1:0]     in_coef_value;
    logic [firl_pkg::SAMPLE_W-1:0]   in_sample;
    logic                            in_block_start;

    // memory ports
    logic                            coef_wr_en;
    logic [AW-1:0]                   coef_wr_addr;
    logic                            hist_wr_en;
    logic [AW-1:0]                   hist_wr_addr;
    logic                            rd_en;
    logic [AW-1:0]                   coef_rd_addr;
    logic [AW-1:0]                   hist_rd_addr;
    logic [firl_pkg::COEF_W-1:0]     coef_rd_data;
    logic [firl_pkg::SAMPLE_W-1:0]   hist_rd_data;

    // sequencer to mac
    firl_pkg::mac_tag_t              tag;
    logic                            res_done;
    logic [firl_pkg::SAMPLE_W-1:0]   res_filtered;
    logic                            res_sat;

    // output register
    logic                            out_free;
    logic                            out_load;
    logic                            m_valid_reg, m_valid_next;
    logic [firl_pkg::SAMPLE_W-1:0]   m_filt_reg, m_filt_next;
    logic                            m_sat_reg, m_sat_next;

    assign in_coef_index  = s_tdata[9:0];
    assign in_coef_value  = s_tdata[25:10];
    assign in_sample      = s_tdata[41:26];
    assign in_block_start = s_tdata[42];
    assign in_op          = s_tuser[0];

    firl_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (in_op),
        .in_coef_index  (in_coef_index),
        .in_block_start (in_block_start),
        .coef_wr_en     (coef_wr_en),
        .coef_wr_addr   (coef_wr_addr),
        .hist_wr_en     (hist_wr_en),
        .hist_wr_addr   (hist_wr_addr),
        .rd_en          (rd_en),
        .coef_rd_addr   (coef_rd_addr),
        .hist_rd_addr   (hist_rd_addr),
        .tag            (tag),
        .res_done       (res_done),
        .out_free       (out_free),
        .out_load       (out_load)
    );

    // coefficient memory, unwritten entries are never relied on
    firl_ram #(
        .WIDTH (firl_pkg::COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (in_coef_value),
        .rd_en   (rd_en),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd_data)
    );

    // circular sample history, stale words masked by the fill count
    firl_ram #(
        .WIDTH (firl_pkg::SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (in_sample),
        .rd_en   (rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    firl_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag),
        .coef         (coef_rd_data),
        .hist         (hist_rd_data),
        .res_done     (res_done),
        .res_filtered (res_filtered),
        .res_sat      (res_sat)
    );

    // output slot frees up in the same cycle the held beat is taken
    always_comb
    begin
        out_free     = !m_valid_reg || m_tready;
        m_valid_next = m_valid_reg;
        m_filt_next  = m_filt_reg;
        m_sat_next   = m_sat_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_filt_next  = res_filtered;
            m_sat_next   = res_sat;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_filt_reg <= m_filt_next;
        m_sat_reg  <= m_sat_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_filt_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule
